// ===== sv/ckset_pkg.sv =====
// Shared types, codes and a bit-search helper for the crit-bit key set.
package ckset_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_WALK,
    S_LEAF,
    S_SCAN,
    S_WALK2,
    S_SPLICE,
    S_LINK
  } state_t;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_FIND   = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_DUP       = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LEAF  = 2'd1;
  localparam logic [1:0] TAG_NODE  = 2'd2;

  // position of the highest set bit of a byte
  function automatic logic [2:0] msb8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

// ===== sv/ckset_msb.sv =====
// Highest-set-bit search over a key difference, one byte per cycle.
module ckset_msb #(
  parameter int KEY_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [KEY_WIDTH-1:0]         x,
  output logic                         found,
  output logic [$clog2(KEY_WIDTH)-1:0] msb
);
  localparam int NCH = (KEY_WIDTH + 7) / 8;
  localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int BW  = $clog2(KEY_WIDTH);

  logic [NCH*8-1:0] xr;
  logic [CHW-1:0]   cnt;
  logic             run;
  logic [7:0]       chunk;
  logic [CHW+2:0]   pos;

  assign chunk = xr[{cnt, 3'b000} +: 8];
  assign found = run && (chunk != 8'd0);
  assign pos   = {cnt, ckset_pkg::msb8(chunk)};
  assign msb   = pos[BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (found) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr  <= (NCH*8)'(x);
      cnt <= CHW'(NCH - 1);
    end else if (run && !found) begin
      cnt <= cnt - CHW'(1);
    end
  end

endmodule

// ===== sv/crit_bit_key_set.sv =====
// Crit-bit tree key set: sequencer, node/leaf memories and free stacks.
//
//  channel  | signals                             | transfer
//  ---------+-------------------------------------+---------------------------
//  request  | req_type, key, exact_only           | start high while busy low
//  result   | status, result_key                  | done high for one cycle
//
// Each tree level is a registered node-memory read whose data selects the next
// address. Insert adds a second walk, a byte-wise crit-bit search and the splice
// and link states. Depth is at most min(MAX_KEYS - 1, KEY_WIDTH).
// After reset the block is ready at once; free stacks read as identity at or above
// a high-water mark. The receiver cannot stall: done lasts one cycle.
module crit_bit_key_set #(
  parameter int MAX_KEYS  = 256,
  parameter int KEY_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic                 exact_only,
  output logic                 done,
  output logic [1:0]           status,
  output logic [KEY_WIDTH-1:0] result_key
);
  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int BW = $clog2(KEY_WIDTH);
  localparam int RW = IW + 2;
  localparam int NN = MAX_KEYS - 1;

  logic [KEY_WIDTH-1:0] leaf_mem [MAX_KEYS];
  logic [BW-1:0]        nbit_mem [NN];
  logic [RW-1:0]        c0_mem   [NN];
  logic [RW-1:0]        c1_mem   [NN];
  logic [IW-1:0]        lstk_mem [MAX_KEYS];
  logic [IW-1:0]        nstk_mem [NN];

  ckset_pkg::state_t state, state_next;
  logic [1:0]           req_op, req_op_next;
  logic [KEY_WIDTH-1:0] req_key, req_key_next;
  logic                 req_exact, req_exact_next;
  logic [RW-1:0]        root, root_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        hw, hw_next;
  logic [RW-1:0]        cur_ref, cur_ref_next;
  logic [IW-1:0]        leaf_idx, leaf_idx_next;
  logic [IW-1:0]        par_idx, par_idx_next;
  logic                 par_side, par_side_next;
  logic [RW-1:0]        sib, sib_next;
  logic                 has_par, has_par_next;
  logic [IW-1:0]        gp_idx, gp_idx_next;
  logic                 gp_side, gp_side_next;
  logic                 has_gp, has_gp_next;
  logic [BW-1:0]        diff_r, diff_r_next;
  logic [RW-1:0]        ins_ref, ins_ref_next;
  logic                 slot_root, slot_root_next;
  logic [IW-1:0]        slot_idx, slot_idx_next;
  logic                 slot_side, slot_side_next;
  logic                 done_next;
  logic [1:0]           status_next;
  logic [KEY_WIDTH-1:0] result_key_next;

  logic [KEY_WIDTH-1:0] leaf_q;
  logic [BW-1:0]        nb_q;
  logic [RW-1:0]        c0_q, c1_q;
  logic [IW-1:0]        lstk_q, nstk_q;

  logic [IW-1:0]        n_raddr, leaf_raddr, lstk_raddr, nstk_raddr;
  logic                 lk_we, nb_we, c0_we, c1_we, ls_we, ns_we;
  logic [IW-1:0]        lk_waddr, nb_waddr, c0_waddr, c1_waddr, ls_waddr, ns_waddr;
  logic [RW-1:0]        c0_wdata, c1_wdata;
  logic [IW-1:0]        ls_wdata, ns_wdata;

  logic [CW-1:0]        cm1, cm2, count_inc;
  logic [IW-1:0]        lf_sel, nd_sel;
  logic                 scan_start, scan_found;
  logic [BW-1:0]        scan_msb;
  logic                 side;
  logic [RW-1:0]        child;

  assign busy      = (state != ckset_pkg::S_IDLE);
  assign cm1       = count - CW'(1);
  assign cm2       = count - CW'(2);
  assign count_inc = count + CW'(1);

  assign lstk_raddr = (count >= CW'(MAX_KEYS)) ? '0 : count[IW-1:0];
  assign nstk_raddr = (count == '0 || count >= CW'(MAX_KEYS)) ? '0 : cm1[IW-1:0];
  assign lf_sel     = (count >= hw) ? count[IW-1:0] : lstk_q;
  assign nd_sel     = (count >= hw) ? cm1[IW-1:0] : nstk_q;

  ckset_msb #(.KEY_WIDTH(KEY_WIDTH)) u_msb (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .x     (leaf_q ^ req_key),
    .found (scan_found),
    .msb   (scan_msb)
  );

  always_ff @(posedge clk) begin
    if (lk_we) leaf_mem[lk_waddr] <= req_key;
    if (nb_we) nbit_mem[nb_waddr] <= diff_r;
    if (c0_we) c0_mem[c0_waddr] <= c0_wdata;
    if (c1_we) c1_mem[c1_waddr] <= c1_wdata;
    if (ls_we) lstk_mem[ls_waddr] <= ls_wdata;
    if (ns_we) nstk_mem[ns_waddr] <= ns_wdata;
    leaf_q <= leaf_mem[leaf_raddr];
    nb_q   <= nbit_mem[n_raddr];
    c0_q   <= c0_mem[n_raddr];
    c1_q   <= c1_mem[n_raddr];
    lstk_q <= lstk_mem[lstk_raddr];
    nstk_q <= nstk_mem[nstk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ckset_pkg::S_IDLE;
      root  <= {ckset_pkg::TAG_EMPTY, IW'(0)};
      count <= '0;
      hw    <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      root  <= root_next;
      count <= count_next;
      hw    <= hw_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    req_op     <= req_op_next;
    req_key    <= req_key_next;
    req_exact  <= req_exact_next;
    cur_ref    <= cur_ref_next;
    leaf_idx   <= leaf_idx_next;
    par_idx    <= par_idx_next;
    par_side   <= par_side_next;
    sib        <= sib_next;
    has_par    <= has_par_next;
    gp_idx     <= gp_idx_next;
    gp_side    <= gp_side_next;
    has_gp     <= has_gp_next;
    diff_r     <= diff_r_next;
    ins_ref    <= ins_ref_next;
    slot_root  <= slot_root_next;
    slot_idx   <= slot_idx_next;
    slot_side  <= slot_side_next;
    status     <= status_next;
    result_key <= result_key_next;
  end

  always_comb begin
    state_next      = state;
    req_op_next     = req_op;
    req_key_next    = req_key;
    req_exact_next  = req_exact;
    root_next       = root;
    count_next      = count;
    hw_next         = hw;
    cur_ref_next    = cur_ref;
    leaf_idx_next   = leaf_idx;
    par_idx_next    = par_idx;
    par_side_next   = par_side;
    sib_next        = sib;
    has_par_next    = has_par;
    gp_idx_next     = gp_idx;
    gp_side_next    = gp_side;
    has_gp_next     = has_gp;
    diff_r_next     = diff_r;
    ins_ref_next    = ins_ref;
    slot_root_next  = slot_root;
    slot_idx_next   = slot_idx;
    slot_side_next  = slot_side;
    done_next       = 1'b0;
    status_next     = status;
    result_key_next = result_key;
    n_raddr    = '0;
    leaf_raddr = '0;
    lk_we = 1'b0; nb_we = 1'b0; c0_we = 1'b0; c1_we = 1'b0; ls_we = 1'b0; ns_we = 1'b0;
    lk_waddr = lf_sel;
    nb_waddr = nd_sel;
    c0_waddr = '0; c1_waddr = '0;
    c0_wdata = '0; c1_wdata = '0;
    ls_waddr = cm1[IW-1:0];
    ls_wdata = leaf_idx;
    ns_waddr = cm2[IW-1:0];
    ns_wdata = par_idx;
    scan_start = 1'b0;
    side  = req_key[nb_q];
    child = side ? c1_q : c0_q;

    case (state)
      ckset_pkg::S_IDLE: begin
        if (start) begin
          state_next     = ckset_pkg::S_DISP;
          req_op_next    = req_type;
          req_key_next   = key;
          req_exact_next = exact_only;
        end
      end
      ckset_pkg::S_DISP: begin
        has_par_next = 1'b0;
        has_gp_next  = 1'b0;
        if (req_op == ckset_pkg::REQ_INSERT && root[RW-1 -: 2] == ckset_pkg::TAG_EMPTY) begin
          lk_we           = 1'b1;
          root_next       = {ckset_pkg::TAG_LEAF, lf_sel};
          count_next      = count_inc;
          if (count_inc > hw) hw_next = count_inc;
          done_next       = 1'b1;
          status_next     = ckset_pkg::STAT_OK;
          result_key_next = req_key;
          state_next      = ckset_pkg::S_IDLE;
        end else if (root[RW-1 -: 2] == ckset_pkg::TAG_EMPTY ||
                     (req_op != ckset_pkg::REQ_INSERT && req_op != ckset_pkg::REQ_FIND &&
                      req_op != ckset_pkg::REQ_REMOVE)) begin
          done_next       = 1'b1;
          status_next     = ckset_pkg::STAT_NOT_FOUND;
          result_key_next = '0;
          state_next      = ckset_pkg::S_IDLE;
        end else if (root[RW-1 -: 2] == ckset_pkg::TAG_NODE) begin
          n_raddr      = root[IW-1:0];
          cur_ref_next = root;
          state_next   = ckset_pkg::S_WALK;
        end else begin
          leaf_raddr    = root[IW-1:0];
          leaf_idx_next = root[IW-1:0];
          state_next    = ckset_pkg::S_LEAF;
        end
      end
      ckset_pkg::S_WALK: begin
        gp_idx_next   = par_idx;
        gp_side_next  = par_side;
        has_gp_next   = has_par;
        par_idx_next  = cur_ref[IW-1:0];
        par_side_next = side;
        sib_next      = side ? c0_q : c1_q;
        has_par_next  = 1'b1;
        if (child[RW-1 -: 2] == ckset_pkg::TAG_NODE) begin
          n_raddr      = child[IW-1:0];
          cur_ref_next = child;
        end else begin
          leaf_raddr    = child[IW-1:0];
          leaf_idx_next = child[IW-1:0];
          state_next    = ckset_pkg::S_LEAF;
        end
      end
      ckset_pkg::S_LEAF: begin
        done_next       = 1'b1;
        status_next     = ckset_pkg::STAT_OK;
        result_key_next = leaf_q;
        state_next      = ckset_pkg::S_IDLE;
        if (req_op == ckset_pkg::REQ_INSERT) begin
          result_key_next = '0;
          if (leaf_q == req_key) begin
            status_next = ckset_pkg::STAT_DUP;
          end else if (count >= CW'(MAX_KEYS)) begin
            status_next = ckset_pkg::STAT_FULL;
          end else begin
            done_next  = 1'b0;
            scan_start = 1'b1;
            state_next = ckset_pkg::S_SCAN;
          end
        end else if (req_op == ckset_pkg::REQ_REMOVE) begin
          if (req_exact && leaf_q != req_key) begin
            status_next     = ckset_pkg::STAT_NOT_FOUND;
            result_key_next = '0;
          end else begin
            if (has_par) begin
              ns_we = 1'b1;
              if (has_gp) begin
                if (gp_side) begin
                  c1_we = 1'b1; c1_waddr = gp_idx; c1_wdata = sib;
                end else begin
                  c0_we = 1'b1; c0_waddr = gp_idx; c0_wdata = sib;
                end
              end else begin
                root_next = sib;
              end
            end else begin
              root_next = {ckset_pkg::TAG_EMPTY, IW'(0)};
            end
            ls_we      = 1'b1;
            count_next = cm1;
          end
        end
      end
      ckset_pkg::S_SCAN: begin
        if (scan_found) begin
          diff_r_next    = scan_msb;
          slot_root_next = 1'b1;
          if (root[RW-1 -: 2] == ckset_pkg::TAG_NODE) begin
            n_raddr      = root[IW-1:0];
            cur_ref_next = root;
            state_next   = ckset_pkg::S_WALK2;
          end else begin
            ins_ref_next = root;
            state_next   = ckset_pkg::S_SPLICE;
          end
        end
      end
      ckset_pkg::S_WALK2: begin
        if (nb_q > diff_r) begin
          slot_root_next = 1'b0;
          slot_idx_next  = cur_ref[IW-1:0];
          slot_side_next = side;
          if (child[RW-1 -: 2] == ckset_pkg::TAG_NODE) begin
            n_raddr      = child[IW-1:0];
            cur_ref_next = child;
          end else begin
            ins_ref_next = child;
            state_next   = ckset_pkg::S_SPLICE;
          end
        end else begin
          ins_ref_next = cur_ref;
          state_next   = ckset_pkg::S_SPLICE;
        end
      end
      ckset_pkg::S_SPLICE: begin
        lk_we    = 1'b1;
        nb_we    = 1'b1;
        c0_we    = 1'b1;
        c1_we    = 1'b1;
        c0_waddr = nd_sel;
        c1_waddr = nd_sel;
        c0_wdata = req_key[diff_r] ? ins_ref : {ckset_pkg::TAG_LEAF, lf_sel};
        c1_wdata = req_key[diff_r] ? {ckset_pkg::TAG_LEAF, lf_sel} : ins_ref;
        state_next = ckset_pkg::S_LINK;
      end
      ckset_pkg::S_LINK: begin
        if (slot_root) begin
          root_next = {ckset_pkg::TAG_NODE, nd_sel};
        end else if (slot_side) begin
          c1_we = 1'b1; c1_waddr = slot_idx; c1_wdata = {ckset_pkg::TAG_NODE, nd_sel};
        end else begin
          c0_we = 1'b1; c0_waddr = slot_idx; c0_wdata = {ckset_pkg::TAG_NODE, nd_sel};
        end
        count_next = count_inc;
        if (count_inc > hw) hw_next = count_inc;
        done_next       = 1'b1;
        status_next     = ckset_pkg::STAT_OK;
        result_key_next = req_key;
        state_next      = ckset_pkg::S_IDLE;
      end
      default: begin
        state_next = ckset_pkg::S_IDLE;
      end
    endcase
  end

endmodule
